>>> rtl/lpr_pkg.sv
// Package for the longest-prefix route lookup block.
// Holds the payload structs, the stored route entry, the opcodes and the FSM states.
// Depends on nothing; every rtl file imports it.
`default_nettype none

package lpr_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam int CountW = 9;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  entry_index;
    logic [31:0] entry_prefix;
    logic [31:0] entry_next_hop;
    logic [31:0] entry_mask;
    logic [7:0]  entry_interface;
    logic [31:0] lookup_address;
  } lpr_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] route_next_hop;
    logic [7:0]  route_interface;
    logic [31:0] route_mask;
    logic [7:0]  route_slot;
  } lpr_out_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] hop;
    logic [31:0] mask;
    logic [7:0]  iface;
  } route_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } lpr_state_t;

endpackage

`default_nettype wire

>>> rtl/longest_prefix_route_lookup.sv
// Top level of the longest-prefix route lookup: route table memory, scan sequencer
// and the shared match/compare unit. Depends on lpr_pkg.
`default_nettype none

// A write word stores one route in the table (slots at or above TABLE_DEPTH
// are dropped) and gives no result. A lookup word scans slots 0 to
// entry_count-1 (entry_count saturates at TABLE_DEPTH) through the table's single
// read port, one slot per cycle, feeding one shared match and mask-compare unit; a
// lookup occupies the block through the scan, the final compare and any wait on out_ready,
// and in_ready stays low until the result is in the output register. A finished
// result waits in that register while the next word is taken. Table contents are
// not cleared at reset: every slot below entry_count must be written before a lookup.
module longest_prefix_route_lookup
  import lpr_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lpr_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lpr_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [CountW-1:0] cfg_wdata
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int CmpW = (CntW > CountW) ? CntW : CountW;

  route_entry_t mem [TABLE_DEPTH];

  lpr_state_t        state_r, state_nxt;
  logic [CountW-1:0] entry_count_r;
  logic [CntW-1:0]   addr_r, addr_nxt;
  logic [CntW-1:0]   limit_r, limit_nxt;
  logic [31:0]       dest_r, dest_nxt;
  logic              pend_r;
  logic [IdxW-1:0]   rd_slot_r;
  route_entry_t      rd_data_r;
  logic              hit_r, hit_nxt;
  logic [31:0]       best_mask_r, best_mask_nxt;
  logic [31:0]       best_hop_r, best_hop_nxt;
  logic [7:0]        best_if_r, best_if_nxt;
  logic [IdxW-1:0]   best_slot_r, best_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  lpr_out_t          out_data_r, out_data_nxt;

  logic              in_acc;
  logic              wr_en;
  logic              rd_en;
  logic [CmpW-1:0]   cnt_ext;
  logic [CmpW-1:0]   depth_c;
  logic              match;
  logic              better;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign wr_en     = in_acc && (in_data.opcode == OP_WRITE)
                     && (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
  assign rd_en     = (state_r == S_SCAN) && (addr_r < limit_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cnt_ext = CmpW'(entry_count_r);
  assign depth_c = CmpW'(TABLE_DEPTH);

  // shared match and compare unit, one stored entry per cycle
  assign match  = ((dest_r & rd_data_r.mask) == rd_data_r.prefix);
  assign better = !hit_r || (rd_data_r.mask >= best_mask_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IdxW'(in_data.entry_index)] <= route_entry_t'{
        prefix:   in_data.entry_prefix,
        hop:      in_data.entry_next_hop,
        mask:     in_data.entry_mask,
        iface:    in_data.entry_interface
      };
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r[IdxW-1:0]];
      rd_slot_r <= addr_r[IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      pend_r        <= 1'b0;
      hit_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= rd_en;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    limit_r     <= limit_nxt;
    dest_r      <= dest_nxt;
    best_mask_r <= best_mask_nxt;
    best_hop_r  <= best_hop_nxt;
    best_if_r   <= best_if_nxt;
    best_slot_r <= best_slot_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    limit_nxt     = limit_r;
    dest_nxt      = dest_r;
    hit_nxt       = hit_r;
    best_mask_nxt = best_mask_r;
    best_hop_nxt  = best_hop_r;
    best_if_nxt   = best_if_r;
    best_slot_nxt = best_slot_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.opcode == OP_LOOKUP)) begin
          addr_nxt  = '0;
          limit_nxt = CntW'((cnt_ext > depth_c) ? depth_c : cnt_ext);
          dest_nxt  = in_data.lookup_address;
          hit_nxt   = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          addr_nxt = addr_r + CntW'(1);
        end
        if (pend_r && match && better) begin
          hit_nxt       = 1'b1;
          best_mask_nxt = rd_data_r.mask;
          best_hop_nxt  = rd_data_r.hop;
          best_if_nxt   = rd_data_r.iface;
          best_slot_nxt = rd_slot_r;
        end
        // last read is being compared this cycle
        if (!rd_en) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (hit_r) begin
            out_data_nxt = lpr_out_t'{
              found:           1'b1,
              route_next_hop:  best_hop_r,
              route_interface: best_if_r,
              route_mask:      best_mask_r,
              route_slot:      8'(best_slot_r)
            };
          end else begin
            out_data_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lpr_checker.sv
// Port-level checker for the longest-prefix route lookup, with its bind to the top level.
// Depends on lpr_pkg and on the top level's port list.
`default_nettype none

module lpr_checker
  import lpr_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire lpr_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire lpr_out_t out_data
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a miss carries all-zero route fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.route_next_hop == '0
      && out_data.route_interface == '0 && out_data.route_mask == '0
      && out_data.route_slot == '0)
    else $error("miss with nonzero route fields");

  // a lookup occupies the block
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_LOOKUP) |=> !in_ready)
    else $error("ready right after a lookup");

  // a table write leaves the block ready
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_WRITE) |=> in_ready)
    else $error("not ready after a table write");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind longest_prefix_route_lookup lpr_checker u_lpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

>>> tb/sv/tb_longest_prefix_route_lookup.sv
// Self-checking testbench for longest_prefix_route_lookup: a directed table, then random
// table fills and lookups over several entry counts, checked by a route predictor.
// Depends on lpr_pkg and the longest_prefix_route_lookup RTL.
module tb_longest_prefix_route_lookup;
  import lpr_pkg::*;

  localparam int RouteDepth = 256;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [8:0]  cfg_value;
    lpr_in_t     word;
    bit          typed;
    lpr_out_t    want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lpr_in_t             in_data;
  logic                out_valid;
  logic                out_ready;
  lpr_out_t            out_data;
  logic                cfg_we;
  logic [CountW-1:0]   cfg_wdata;

  route_entry_t route_table [RouteDepth];
  bit           route_written [RouteDepth];
  int           route_count;
  logic [31:0]  route_bases [4];
  lpr_out_t     expected_routes [$];

  int words_sent;
  int lookups_sent;
  int routes_checked;
  int mismatches;
  int sizes_used;
  int in_run;
  int out_run;

  longest_prefix_route_lookup #(
    .TABLE_DEPTH(RouteDepth)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Wait drawn per word; now and then a run of back-to-back words.
  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run = int'($urandom_range(4, 30));
      return 0;
    end
    return int'($urandom_range(0, 14));
  endfunction

  function automatic lpr_out_t predict_route(logic [31:0] dest);
    lpr_out_t    r;
    logic [31:0] best_mask;
    int          best_slot;
    int          limit;
    bit          hit;
    r = '0;
    best_mask = '0;
    best_slot = 0;
    hit = 1'b0;
    limit = (route_count > RouteDepth) ? RouteDepth : route_count;
    for (int i = 0; i < limit; i++) begin
      // Equal masks go to the later slot.
      if ((dest & route_table[i].mask) == route_table[i].prefix &&
          (!hit || route_table[i].mask >= best_mask)) begin
        hit = 1'b1;
        best_mask = route_table[i].mask;
        best_slot = i;
      end
    end
    if (hit) begin
      r.found = 1'b1;
      r.route_next_hop = route_table[best_slot].hop;
      r.route_interface = route_table[best_slot].iface;
      r.route_mask = route_table[best_slot].mask;
      r.route_slot = 8'(best_slot);
    end
    return r;
  endfunction

  // Random write word; most prefixes sit under one of a few shared bases so routes overlap.
  function automatic lpr_in_t make_route(int idx);
    lpr_in_t     w;
    int          len;
    logic [31:0] m;
    len = int'($urandom_range(0, 32));
    m = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    if ($urandom_range(0, 9) == 0) m = $urandom;
    w.opcode = OP_WRITE;
    w.entry_index = 8'(idx);
    w.entry_mask = m;
    w.entry_prefix = ($urandom_range(0, 7) == 0) ? $urandom
                                                  : (route_bases[$urandom_range(0, 3)] & m);
    w.entry_next_hop = $urandom;
    w.entry_interface = 8'($urandom);
    w.lookup_address = $urandom;
    return w;
  endfunction

  function automatic dir_row_t wr_row(int idx, logic [31:0] prefix, logic [31:0] hop,
                                      logic [31:0] mask, logic [7:0] iface);
    dir_row_t row;
    row.kind = ROW_WORD;
    row.cfg_value = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.word.opcode = OP_WRITE;
    row.word.entry_index = 8'(idx);
    row.word.entry_prefix = prefix;
    row.word.entry_next_hop = hop;
    row.word.entry_mask = mask;
    row.word.entry_interface = iface;
    row.word.lookup_address = $urandom;
    return row;
  endfunction

  function automatic dir_row_t lk_row(logic [31:0] addr);
    dir_row_t row;
    row.kind = ROW_WORD;
    row.cfg_value = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.word = make_route(0);
    row.word.opcode = OP_LOOKUP;
    row.word.lookup_address = addr;
    return row;
  endfunction

  function automatic dir_row_t lk_hit(logic [31:0] addr, logic [31:0] hop, logic [7:0] iface,
                                      logic [31:0] mask, logic [7:0] idx);
    dir_row_t row;
    row = lk_row(addr);
    row.typed = 1'b1;
    row.want.found = 1'b1;
    row.want.route_next_hop = hop;
    row.want.route_interface = iface;
    row.want.route_mask = mask;
    row.want.route_slot = idx;
    return row;
  endfunction

  function automatic dir_row_t lk_miss(logic [31:0] addr);
    dir_row_t row;
    row = lk_row(addr);
    row.typed = 1'b1;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [8:0] value);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.cfg_value = value;
    row.word = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH route %0d %s: got %h expected %h", routes_checked, field, got, want);
    mismatches++;
  endtask

  task automatic issue_word(lpr_in_t w, bit typed, lpr_out_t want);
    int gap;
    gap = draw_wait(in_run);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
    if (w.opcode == OP_WRITE) begin
      route_table[w.entry_index].prefix = w.entry_prefix;
      route_table[w.entry_index].hop = w.entry_next_hop;
      route_table[w.entry_index].mask = w.entry_mask;
      route_table[w.entry_index].iface = w.entry_interface;
      route_written[w.entry_index] = 1'b1;
    end else begin
      expected_routes.push_back(typed ? want : predict_route(w.lookup_address));
      lookups_sent++;
    end
  endtask

  // Change entry_count only once the block has drained.
  task automatic set_entry_count(logic [8:0] value);
    in_valid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    route_count = int'(value);
    sizes_used++;
  endtask

  // Result side: random stalls on out_ready, check every accepted word.
  initial begin
    int       stall;
    lpr_out_t got;
    lpr_out_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(out_run);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = out_data;
      if (expected_routes.size() == 0) begin
        report_mismatch("unexpected word, next hop", got.route_next_hop, '0);
      end else begin
        want = expected_routes.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.route_next_hop !== want.route_next_hop)
          report_mismatch("next hop", got.route_next_hop, want.route_next_hop);
        if (got.route_interface !== want.route_interface)
          report_mismatch("interface", 32'(got.route_interface), 32'(want.route_interface));
        if (got.route_mask !== want.route_mask)
          report_mismatch("mask", got.route_mask, want.route_mask);
        if (got.route_slot !== want.route_slot)
          report_mismatch("index", 32'(got.route_slot), 32'(want.route_slot));
      end
      routes_checked++;
    end
  end

  initial begin
    dir_row_t    dir_rows [$];
    lpr_in_t     w;
    route_entry_t e;
    logic [31:0] addr;
    int          phase;
    int          count;
    int          limit;
    int          pick;
    int          n;
    int          random_start;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    route_count = 0;
    words_sent = 0;
    lookups_sent = 0;
    routes_checked = 0;
    mismatches = 0;
    sizes_used = 0;
    in_run = 0;
    out_run = 0;
    for (int i = 0; i < 4; i++) route_bases[i] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows.push_back(lk_miss(32'h0000_0000));
    dir_rows.push_back(wr_row(0, 32'h0000_0000, 32'h0A00_0001, 32'h0000_0000, 8'h01));
    dir_rows.push_back(wr_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    dir_rows.push_back(wr_row(2, 32'hC0A8_0000, 32'hC0A8_0001, 32'hFFFF_0000, 8'h02));
    dir_rows.push_back(wr_row(3, 32'hC0A8_0100, 32'hC0A8_0101, 32'hFFFF_FF00, 8'h03));
    dir_rows.push_back(wr_row(4, 32'hC0A8_0000, 32'h0B00_0004, 32'hFFFF_0000, 8'h04));
    dir_rows.push_back(wr_row(5, 32'h1020_3040, 32'h0000_0055, 32'hF0F0_F0F0, 8'h05));
    dir_rows.push_back(wr_row(6, 32'h0000_0001, 32'h0000_0066, 32'hFFFF_FF00, 8'h06));
    dir_rows.push_back(wr_row(255, 32'h0000_0000, 32'h0000_DEAD, 32'h0000_0000, 8'hFF));
    dir_rows.push_back(cfg_row(9'd1));
    dir_rows.push_back(lk_hit(32'hFFFF_FFFF, 32'h0A00_0001, 8'h01, 32'h0000_0000, 8'd0));
    dir_rows.push_back(lk_hit(32'h0000_0000, 32'h0A00_0001, 8'h01, 32'h0000_0000, 8'd0));
    dir_rows.push_back(cfg_row(9'd7));
    dir_rows.push_back(lk_hit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'd1));
    dir_rows.push_back(lk_row(32'hC0A8_0105));
    dir_rows.push_back(lk_row(32'hC0A8_0205));
    dir_rows.push_back(lk_row(32'h1A2B_3C4D));
    dir_rows.push_back(lk_row(32'h0000_0001));
    dir_rows.push_back(cfg_row(9'd0));
    dir_rows.push_back(lk_miss(32'hC0A8_0105));
    dir_rows.push_back(wr_row(0, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000, 8'h80));
    dir_rows.push_back(cfg_row(9'd2));
    dir_rows.push_back(lk_miss(32'h7FFF_FFFF));
    dir_rows.push_back(lk_row(32'h8000_0000));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) set_entry_count(dir_rows[i].cfg_value);
      else issue_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases: first the saturating counts and a full table, then mostly small ones.
    random_start = words_sent;
    phase = 0;
    while (words_sent - random_start < 400 || lookups_sent < 100) begin
      pick = int'($urandom_range(0, 9));
      if (phase == 0) count = 511;
      else if (phase == 1) count = 257;
      else if (phase == 2) count = 256;
      else if (pick == 0) count = 0;
      else if (pick < 6) count = int'($urandom_range(1, 16));
      else if (pick < 8) count = int'($urandom_range(17, 64));
      else if (pick < 9) count = int'($urandom_range(65, 256));
      else count = int'($urandom_range(257, 511));
      limit = (count > RouteDepth) ? RouteDepth : count;
      // Fill every slot the scan will reach before the new count takes effect.
      for (int i = 0; i < limit; i++) begin
        if (!route_written[i]) issue_word(make_route(i), 1'b0, '0);
      end
      set_entry_count(9'(count));
      n = int'($urandom_range(10, 40));
      repeat (n) begin
        if ($urandom_range(0, 9) < 6) begin
          pick = int'($urandom_range(0, 9));
          if (limit > 0 && pick < 7) begin
            e = route_table[$urandom_range(0, limit - 1)];
            addr = e.prefix | ($urandom & ~e.mask);
          end else if (pick < 9) begin
            addr = route_bases[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(0, 31));
          end else begin
            addr = $urandom;
          end
          w = make_route(int'($urandom_range(0, 255)));
          w.opcode = OP_LOOKUP;
          w.lookup_address = addr;
        end else begin
          w = make_route(int'($urandom_range(0, 255)));
        end
        issue_word(w, 1'b0, '0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d words (%0d lookups) across %0d entry_count settings",
             words_sent, lookups_sent, sizes_used);
    $display("Checked %0d route results, %0d mismatches", routes_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
